### rtl/core/chfm_pkg.sv
package chfm_pkg;

  localparam int CHFM_ITER_DEFAULT = 14;
  localparam int ATAN_TABLE_SIZE   = 24;

  localparam int RAW_W     = 16;
  localparam int AXIS_W    = 18;
  localparam int PRESHIFT  = 20;
  // Rotated vector grows by the CORDIC gain and up to sqrt(2) over the scaled axis.
  localparam int XY_W      = 42;
  localparam int Z_W       = 33;
  localparam int ANG_W     = 18;
  localparam int HEAD_W    = 16;
  localparam int DEG_K_W   = 24;

  localparam logic signed [Z_W-1:0]   HALF_PI_Q29     = 33'sd843314857;
  localparam logic signed [ANG_W-1:0] TWO_PI_Q13      = 18'sd51472;
  localparam logic [DEG_K_W-1:0]      DEG_PER_RAD_Q24 = 24'd15019745;

  localparam logic [15:0] GAIN_RESET = 16'd60293;
  localparam logic [15:0] DECL_RESET = 16'd374;

  typedef enum logic [1:0] {
    REG_GAIN    = 2'd0,
    REG_DECL    = 2'd1,
    REG_PRESENT = 2'd2,
    REG_SPARE   = 2'd3
  } chfm_reg_t;

  // Data that moves from one angle cell to the next.
  typedef struct packed {
    logic                     present;
    logic                     zero;
    logic signed [AXIS_W-1:0] xf;
    logic signed [AXIS_W-1:0] yf;
    logic signed [AXIS_W-1:0] zf;
    logic signed [XY_W-1:0]   cx;
    logic signed [XY_W-1:0]   cy;
    logic signed [Z_W-1:0]    cz;
  } chfm_stage_t;

  // atan(2^-i) in Q.29 radians.
  function automatic logic signed [Z_W-1:0] chfm_atan(input int idx);
    logic signed [Z_W-1:0] v;
    case (idx)
      0:  v = 33'sd421657428;
      1:  v = 33'sd248918915;
      2:  v = 33'sd131521918;
      3:  v = 33'sd66762579;
      4:  v = 33'sd33510843;
      5:  v = 33'sd16771758;
      6:  v = 33'sd8387925;
      7:  v = 33'sd4194219;
      8:  v = 33'sd2097141;
      9:  v = 33'sd1048575;
      10: v = 33'sd524288;
      11: v = 33'sd262144;
      12: v = 33'sd131072;
      13: v = 33'sd65536;
      14: v = 33'sd32768;
      15: v = 33'sd16384;
      16: v = 33'sd8192;
      17: v = 33'sd4096;
      18: v = 33'sd2048;
      19: v = 33'sd1024;
      20: v = 33'sd512;
      21: v = 33'sd256;
      22: v = 33'sd128;
      23: v = 33'sd64;
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage

### rtl/core/chfm_scale.sv
module chfm_scale
  import chfm_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    en,
  input  logic                    in_vld,
  input  logic signed [RAW_W-1:0] x_raw,
  input  logic signed [RAW_W-1:0] y_raw,
  input  logic signed [RAW_W-1:0] z_raw,
  input  logic [15:0]             gain,
  input  logic                    present,
  output logic                    out_vld,
  output chfm_stage_t             out_stage
);

  logic                     vld1_r;
  logic                     present1_r;
  logic signed [AXIS_W-1:0] xf1_r, yf1_r, zf1_r;
  logic signed [AXIS_W-1:0] xf_nxt, yf_nxt, zf_nxt;
  logic                     vld2_r;
  chfm_stage_t              stage2_r, stage2_nxt;
  logic signed [XY_W-1:0]   xs, ys;

  function automatic logic signed [AXIS_W-1:0] scale_one(
    input logic signed [RAW_W-1:0] raw,
    input logic [15:0]             g
  );
    logic signed [33:0] p;
    p = 34'(raw) * 34'($signed({1'b0, g})) + 34'sd8192;
    return p[14+AXIS_W-1:14];
  endfunction

  always_comb begin
    xf_nxt = scale_one(x_raw, gain);
    yf_nxt = scale_one(y_raw, gain);
    zf_nxt = scale_one(z_raw, gain);
  end

  // Pre-rotation by a quarter turn brings a vector with negative X into the right half plane.
  always_comb begin
    xs = XY_W'(xf1_r) <<< PRESHIFT;
    ys = XY_W'(yf1_r) <<< PRESHIFT;
    stage2_nxt.present = present1_r;
    stage2_nxt.zero    = (xf1_r == '0) && (yf1_r == '0);
    stage2_nxt.xf      = xf1_r;
    stage2_nxt.yf      = yf1_r;
    stage2_nxt.zf      = zf1_r;
    stage2_nxt.cx      = xs;
    stage2_nxt.cy      = ys;
    stage2_nxt.cz      = '0;
    if (xf1_r < 0) begin
      if (yf1_r >= 0) begin
        stage2_nxt.cx = ys;
        stage2_nxt.cy = -xs;
        stage2_nxt.cz = HALF_PI_Q29;
      end else begin
        stage2_nxt.cx = -ys;
        stage2_nxt.cy = xs;
        stage2_nxt.cz = -HALF_PI_Q29;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld1_r <= 1'b0;
      vld2_r <= 1'b0;
    end else if (en) begin
      vld1_r <= in_vld;
      vld2_r <= vld1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      present1_r <= present;
      xf1_r      <= xf_nxt;
      yf1_r      <= yf_nxt;
      zf1_r      <= zf_nxt;
      stage2_r   <= stage2_nxt;
    end
  end

  assign out_vld   = vld2_r;
  assign out_stage = stage2_r;

endmodule

### rtl/core/chfm_cordic_cell.sv
module chfm_cordic_cell
  import chfm_pkg::*;
#(
  parameter int SHIFT = 0
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        en,
  input  logic        in_vld,
  input  chfm_stage_t in_stage,
  output logic        out_vld,
  output chfm_stage_t out_stage
);

  logic                   vld_r;
  chfm_stage_t            stage_r, stage_nxt;
  logic signed [XY_W-1:0] dx, dy;

  always_comb begin
    dx        = in_stage.cy >>> SHIFT;
    dy        = in_stage.cx >>> SHIFT;
    stage_nxt = in_stage;
    if (in_stage.cy >= 0) begin
      stage_nxt.cx = in_stage.cx + dx;
      stage_nxt.cy = in_stage.cy - dy;
      stage_nxt.cz = in_stage.cz + chfm_atan(SHIFT);
    end else begin
      stage_nxt.cx = in_stage.cx - dx;
      stage_nxt.cy = in_stage.cy + dy;
      stage_nxt.cz = in_stage.cz - chfm_atan(SHIFT);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (en) begin
      vld_r <= in_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      stage_r <= stage_nxt;
    end
  end

  assign out_vld   = vld_r;
  assign out_stage = stage_r;

endmodule

### rtl/core/chfm_finish.sv
module chfm_finish
  import chfm_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     en,
  input  logic                     in_vld,
  input  chfm_stage_t              in_stage,
  input  logic signed [15:0]       decl,
  output logic                     out_vld,
  output logic                     out_present,
  output logic signed [AXIS_W-1:0] out_xf,
  output logic signed [AXIS_W-1:0] out_yf,
  output logic signed [AXIS_W-1:0] out_zf,
  output logic [HEAD_W-1:0]        out_rad,
  output logic [HEAD_W-1:0]        out_deg
);

  logic                     vld_a_r, vld_b_r, vld_c_r;
  logic                     pres_a_r, pres_b_r;
  logic signed [AXIS_W-1:0] xa_r, ya_r, za_r, xb_r, yb_r, zb_r;
  logic signed [ANG_W-1:0]  h_a_r, h_a_nxt;
  logic [HEAD_W-1:0]        h_b_r, h_b_nxt;
  logic signed [Z_W:0]      zr;
  logic signed [ANG_W-1:0]  ang;
  logic [HEAD_W+DEG_K_W-1:0] deg_prod;
  logic                     pres_c_r;
  logic signed [AXIS_W-1:0] xc_r, yc_r, zc_r;
  logic [HEAD_W-1:0]        rad_c_r, deg_c_r;

  // Round the angle to Q3.13; a zero vector counts as angle zero.
  always_comb begin
    zr      = (Z_W+1)'(in_stage.cz) + (Z_W+1)'(32768);
    ang     = in_stage.zero ? '0 : zr[16+ANG_W-1:16];
    h_a_nxt = ang + ANG_W'(decl);
  end

  // The heading sum can lie below minus one full turn, so two turns may be added.
  always_comb begin
    if (h_a_r < -TWO_PI_Q13) begin
      h_b_nxt = HEAD_W'(h_a_r + TWO_PI_Q13 + TWO_PI_Q13);
    end else if (h_a_r < 0) begin
      h_b_nxt = HEAD_W'(h_a_r + TWO_PI_Q13);
    end else if (h_a_r >= TWO_PI_Q13) begin
      h_b_nxt = HEAD_W'(h_a_r - TWO_PI_Q13);
    end else begin
      h_b_nxt = HEAD_W'(h_a_r);
    end
  end

  assign deg_prod = (HEAD_W+DEG_K_W)'(h_b_r) * (HEAD_W+DEG_K_W)'(DEG_PER_RAD_Q24)
                  + (HEAD_W+DEG_K_W)'(1 << (DEG_K_W-1));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_a_r <= 1'b0;
      vld_b_r <= 1'b0;
      vld_c_r <= 1'b0;
    end else if (en) begin
      vld_a_r <= in_vld;
      vld_b_r <= vld_a_r;
      vld_c_r <= vld_b_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      pres_a_r <= in_stage.present;
      xa_r     <= in_stage.xf;
      ya_r     <= in_stage.yf;
      za_r     <= in_stage.zf;
      h_a_r    <= h_a_nxt;
      pres_b_r <= pres_a_r;
      xb_r     <= xa_r;
      yb_r     <= ya_r;
      zb_r     <= za_r;
      h_b_r    <= h_b_nxt;
      // Without the sensor every field of the result reads zero.
      pres_c_r <= pres_b_r;
      xc_r     <= pres_b_r ? xb_r : '0;
      yc_r     <= pres_b_r ? yb_r : '0;
      zc_r     <= pres_b_r ? zb_r : '0;
      rad_c_r  <= pres_b_r ? h_b_r : '0;
      deg_c_r  <= pres_b_r ? deg_prod[DEG_K_W+HEAD_W-1:DEG_K_W] : '0;
    end
  end

  assign out_vld     = vld_c_r;
  assign out_present = pres_c_r;
  assign out_xf      = xc_r;
  assign out_yf      = yc_r;
  assign out_zf      = zc_r;
  assign out_rad     = rad_c_r;
  assign out_deg     = deg_c_r;

endmodule

### rtl/core/compass_heading_from_magnetometer_core.sv
// Magnetometer compass heading. Each request carries one raw X/Y/Z sample (low byte first);
// the result holds the three axes scaled by the gain register (milligauss, Q.2), and the
// heading atan2(y, x) plus declination wrapped into [0, 2*pi) in radians (Q3.13) and in
// degrees (Q9.7). A new request is taken every clock cycle unless out_tready stalls. Two
// registers do gain scaling and quadrant pre-rotation, one per CORDIC cell follows, and
// three do rounding with declination, turn wrapping and the degree multiply. The whole
// pipeline, output register included, holds while a result waits on out_tready. Registers
// must be written only while the block is idle; the block itself does not enforce this.
module compass_heading_from_magnetometer_core
  import chfm_pkg::*;
#(
  parameter int ANGLE_ITERATIONS = CHFM_ITER_DEFAULT
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  // x_low, x_high, y_low, y_high, z_low, z_high
  input  logic [47:0] in_tdata,
  output logic        out_tvalid,
  input  logic        out_tready,
  // x_field, y_field, z_field, heading_radians, heading_degrees, two pad bits
  output logic [87:0] out_tdata,
  // valid_res
  output logic        out_tuser,
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [3:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);

  logic [15:0]       gain_r;
  logic signed [15:0] decl_r;
  logic              present_r;
  logic              wr;
  chfm_reg_t         reg_sel;
  logic              adv;

  logic              cell_vld   [ANGLE_ITERATIONS+1];
  chfm_stage_t       cell_stage [ANGLE_ITERATIONS+1];

  logic                     fin_present;
  logic signed [AXIS_W-1:0] fin_xf, fin_yf, fin_zf;
  logic [HEAD_W-1:0]        fin_rad, fin_deg;

  assign reg_sel    = chfm_reg_t'(cfg_paddr[3:2]);
  assign wr         = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;
  assign cfg_pready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gain_r    <= GAIN_RESET;
      decl_r    <= DECL_RESET;
      present_r <= 1'b0;
    end else if (wr) begin
      case (reg_sel)
        REG_GAIN:    gain_r    <= cfg_pwdata[15:0];
        REG_DECL:    decl_r    <= cfg_pwdata[15:0];
        REG_PRESENT: present_r <= cfg_pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_sel)
      REG_GAIN:    cfg_prdata = {16'd0, gain_r};
      REG_DECL:    cfg_prdata = {{16{decl_r[15]}}, decl_r};
      REG_PRESENT: cfg_prdata = {31'd0, present_r};
      default:     cfg_prdata = '0;
    endcase
  end

  assign adv       = !out_tvalid || out_tready;
  assign in_tready = adv;

  chfm_scale u_scale (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (adv),
    .in_vld    (in_tvalid),
    .x_raw     ($signed(in_tdata[15:0])),
    .y_raw     ($signed(in_tdata[31:16])),
    .z_raw     ($signed(in_tdata[47:32])),
    .gain      (gain_r),
    .present   (present_r),
    .out_vld   (cell_vld[0]),
    .out_stage (cell_stage[0])
  );

  for (genvar i = 0; i < ANGLE_ITERATIONS; i++) begin : g_cell
    chfm_cordic_cell #(
      .SHIFT (i)
    ) u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .en        (adv),
      .in_vld    (cell_vld[i]),
      .in_stage  (cell_stage[i]),
      .out_vld   (cell_vld[i+1]),
      .out_stage (cell_stage[i+1])
    );
  end

  chfm_finish u_finish (
    .clk         (clk),
    .rst_n       (rst_n),
    .en          (adv),
    .in_vld      (cell_vld[ANGLE_ITERATIONS]),
    .in_stage    (cell_stage[ANGLE_ITERATIONS]),
    .decl        (decl_r),
    .out_vld     (out_tvalid),
    .out_present (fin_present),
    .out_xf      (fin_xf),
    .out_yf      (fin_yf),
    .out_zf      (fin_zf),
    .out_rad     (fin_rad),
    .out_deg     (fin_deg)
  );

  assign out_tuser = fin_present;
  assign out_tdata = {2'b00, fin_deg, fin_rad, fin_zf, fin_yf, fin_xf};

endmodule

### tb/tb_top.sv
`timescale 1ns / 100ps

module tb_top;
  import chfm_pkg::*;

  localparam int ANGLE_STEPS  = 14;
  localparam int LATENCY      = ANGLE_STEPS + 5;
  localparam int STALL_CYCLES = 300;
  localparam int PHASE_ITEMS  = 255;
  localparam int NUM_PHASES   = 6;
  localparam int NUM_DIRECTED = 20;

  typedef struct {
    bit        valid;
    bit [17:0] xf;
    bit [17:0] yf;
    bit [17:0] zf;
    bit [15:0] rad;
    bit [15:0] deg;
  } heading_result_t;

  // Directed samples, packed {z, y, x} with each axis as {high byte, low byte}.
  localparam bit [47:0] DIRECTED [NUM_DIRECTED] = '{
    {16'h0000, 16'h0000, 16'h0000},
    {16'h7FFF, 16'h7FFF, 16'h7FFF},
    {16'h8000, 16'h8000, 16'h8000},
    {16'hFFFF, 16'h0000, 16'hFFFF},
    {16'h0000, 16'h0000, 16'h8000},
    {16'h0000, 16'h0000, 16'h7FFF},
    {16'h0000, 16'h7FFF, 16'h0000},
    {16'h0000, 16'h8000, 16'h0000},
    {16'h0000, 16'hFFFF, 16'h8000},
    {16'h0000, 16'h0001, 16'h8000},
    {16'h1234, 16'h8000, 16'h0001},
    {16'h0080, 16'hFF00, 16'h00FF},
    {16'h7F80, 16'h00FF, 16'h0100},
    {16'h0001, 16'hFFFF, 16'hFFFF},
    {16'h8000, 16'h0001, 16'h0001},
    {16'h5A5A, 16'hEDCB, 16'h1234},
    {16'hFFFE, 16'h5A5A, 16'hA5A5},
    {16'h0000, 16'hFFFF, 16'h7FFF},
    {16'h0000, 16'h0001, 16'hFFFF},
    {16'hFFFF, 16'h8000, 16'h8000}
  };

  class heading_tracker;
    int unsigned     steps;
    bit [15:0]       gain;
    shortint         decl;
    bit              present;
    heading_result_t expected_q[$];
    int unsigned     accepted;
    int unsigned     checked;
    int unsigned     errors;
    longint          atan_step [24] = '{
      421657428, 248918915, 131521918, 66762579, 33510843, 16771758, 8387925, 4194219,
      2097141, 1048575, 524288, 262144, 131072, 65536, 32768, 16384,
      8192, 4096, 2048, 1024, 512, 256, 128, 64
    };

    function new(int unsigned n);
      steps   = n;
      gain    = 16'd60293;
      decl    = 374;
      present = 1'b0;
    endfunction

    function void set_register(chfm_reg_t idx, bit [31:0] v);
      case (idx)
        REG_GAIN:    gain = v[15:0];
        REG_DECL:    decl = v[15:0];
        REG_PRESENT: present = v[0];
        default: ;
      endcase
    endfunction

    function longint scale_axis(bit [15:0] raw);
      shortint r;
      r = raw;
      return (longint'(r) * longint'(gain) + 8192) >>> 14;
    endfunction

    // Vectoring CORDIC on the axes shifted up by 20 bits; angle in Q.29.
    function longint angle_q29(longint xa, longint ya);
      longint x, y, z, dx, dy, t;
      if (xa == 0 && ya == 0) return 0;
      x = xa <<< 20;
      y = ya <<< 20;
      z = 0;
      if (x < 0) begin
        t = x;
        if (y >= 0) begin
          x = y;
          y = -t;
          z = 843314857;
        end else begin
          x = -y;
          y = t;
          z = -843314857;
        end
      end
      for (int i = 0; i < steps && i < 24; i++) begin
        dx = y >>> i;
        dy = x >>> i;
        if (y >= 0) begin
          x += dx;
          y -= dy;
          z += atan_step[i];
        end else begin
          x -= dx;
          y += dy;
          z -= atan_step[i];
        end
      end
      return z;
    endfunction

    function heading_result_t predict_heading(bit [47:0] s);
      heading_result_t r;
      longint xf, yf, zf, h;
      r = '{default: 0};
      if (!present) return r;
      xf = scale_axis(s[15:0]);
      yf = scale_axis(s[31:16]);
      zf = scale_axis(s[47:32]);
      h = ((angle_q29(xf, yf) + 32768) >>> 16) + longint'(decl);
      for (int k = 0; k < 4 && h < 0; k++) h += 51472;
      for (int k = 0; k < 4 && h >= 51472; k++) h -= 51472;
      r.valid = 1'b1;
      r.xf    = xf[17:0];
      r.yf    = yf[17:0];
      r.zf    = zf[17:0];
      r.rad   = h[15:0];
      r.deg   = 16'((h * 15019745 + 8388608) >> 24);
      return r;
    endfunction

    function void note_sample(bit [47:0] s);
      expected_q.push_back(predict_heading(s));
      accepted++;
    endfunction

    function int pending();
      return expected_q.size();
    endfunction

    task report_mismatch(string msg);
      errors++;
      $display("ERROR @%0t: %s", $time, msg);
    endtask

    task compare_field(string name, logic [31:0] got, bit [31:0] want);
      if (got !== want)
        report_mismatch($sformatf("%s got %h expected %h", name, got, want));
    endtask

    task check_result(logic [87:0] d, logic flag);
      heading_result_t want;
      if (expected_q.size() == 0) begin
        report_mismatch($sformatf("result %h with no request outstanding", d));
        return;
      end
      want = expected_q.pop_front();
      checked++;
      compare_field("valid_res", flag, want.valid);
      compare_field("x_field", d[17:0], want.xf);
      compare_field("y_field", d[35:18], want.yf);
      compare_field("z_field", d[53:36], want.zf);
      compare_field("heading_radians", d[69:54], want.rad);
      compare_field("heading_degrees", d[85:70], want.deg);
    endtask
  endclass

  logic        clk = 1'b0;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [47:0] in_tdata;
  logic        out_tvalid;
  logic        out_tready;
  logic [87:0] out_tdata;
  logic        out_tuser;
  logic        cfg_psel;
  logic        cfg_penable;
  logic        cfg_pwrite;
  logic [3:0]  cfg_paddr;
  logic [31:0] cfg_pwdata;
  logic [31:0] cfg_prdata;
  logic        cfg_pready;

  int unsigned send_idle_pct;
  int unsigned recv_idle_pct;
  bit          stall_request;
  int unsigned settings_used;

  heading_tracker tracker = new(ANGLE_STEPS);

  compass_heading_from_magnetometer_core #(
    .ANGLE_ITERATIONS(ANGLE_STEPS)
  ) dut (.*);

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (in_tvalid && in_tready) tracker.note_sample(in_tdata);
      if (out_tvalid && out_tready) tracker.check_result(out_tdata, out_tuser);
    end
  end

  // Result side: random back-pressure, plus one long hold-off on request.
  initial begin
    out_tready = 1'b0;
    forever begin
      @(posedge clk);
      if (stall_request) begin
        stall_request = 1'b0;
        out_tready <= 1'b0;
        for (int n = 0; n < STALL_CYCLES; n++) @(posedge clk);
      end else begin
        out_tready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  initial begin
    #2_000_000;
    $display("Timeout with %0d results outstanding", tracker.pending());
    $display("*** FAILED ***");
    $finish;
  end

  task automatic set_idling(int mode);
    case (mode)
      0: begin
        send_idle_pct = 6;
        recv_idle_pct = 54;
      end
      1: begin
        send_idle_pct = 54;
        recv_idle_pct = 6;
      end
      default: begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
    endcase
  endtask

  task automatic write_reg(chfm_reg_t idx, bit [31:0] value);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= {idx, 2'b00};
    cfg_pwdata  <= value;
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    while (!cfg_pready) @(posedge clk);
    tracker.set_register(idx, value);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    @(posedge clk);
  endtask

  // Valid stays high between back-to-back requests and only drops while idling or in drain().
  task automatic send_sample(bit [47:0] s);
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= s;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
  endtask

  task automatic drain();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (tracker.pending() != 0) @(posedge clk);
  endtask

  function automatic bit [15:0] random_axis();
    case ($urandom_range(9))
      0: return 16'h0000;
      1: begin
        case ($urandom_range(3))
          0: return 16'h7FFF;
          1: return 16'h8000;
          2: return 16'hFFFF;
          default: return 16'h0001;
        endcase
      end
      2, 3: return 16'($urandom_range(16)) - 16'd8;
      default: return 16'($urandom);
    endcase
  endfunction

  initial begin
    bit [15:0] gain;
    int        decl;
    rst_n         = 1'b0;
    in_tvalid     = 1'b0;
    in_tdata      = '0;
    cfg_psel      = 1'b0;
    cfg_penable   = 1'b0;
    cfg_pwrite    = 1'b0;
    cfg_paddr     = '0;
    cfg_pwdata    = '0;
    stall_request = 1'b0;
    settings_used = 1;
    set_idling(0);
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Sensor absent after reset: every result must come back all zero.
    for (int i = 0; i < 3; i++) send_sample(DIRECTED[i]);
    drain();
    write_reg(REG_PRESENT, 32'd1);
    settings_used++;
    for (int i = 0; i < NUM_DIRECTED; i++) send_sample(DIRECTED[i]);
    drain();

    for (int p = 0; p < NUM_PHASES; p++) begin
      case (p)
        0: begin
          gain = 16'd60293;
          decl = 25736;
        end
        1: begin
          gain = 16'hFFFF;
          decl = -25736;
        end
        2: begin
          gain = 16'd0;
          decl = 0;
        end
        3: begin
          gain = 16'd1;
          decl = -1;
        end
        default: begin
          gain = 16'($urandom);
          decl = int'($urandom_range(51472)) - 25736;
        end
      endcase
      set_idling(p % 3);
      write_reg(REG_GAIN, {16'd0, gain});
      write_reg(REG_DECL, 32'(decl));
      write_reg(REG_PRESENT, (p == 4) ? 32'd0 : 32'd1);
      settings_used++;
      // Hold the result side off long enough that the pipeline backs up.
      if (p == 0) stall_request = 1'b1;
      for (int i = 0; i < PHASE_ITEMS; i++) send_sample({random_axis(), random_axis(), random_axis()});
      drain();
    end

    repeat (LATENCY + 10) @(posedge clk);
    if (tracker.pending() != 0)
      tracker.report_mismatch($sformatf("%0d expected results never arrived", tracker.pending()));
    $display("Run covered %0d samples and %0d checked results over %0d register settings,",
             tracker.accepted, tracker.checked, settings_used);
    $display("with gain and declination extremes, sensor absent, and a %0d-cycle output stall.",
             STALL_CYCLES);
    if (tracker.errors == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("%0d mismatches", tracker.errors);
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
